@@ design/memory_controller_register_window_assert.svh @@
// Assertion macros for the register window.
`ifndef MEMORY_CONTROLLER_REGISTER_WINDOW_ASSERT_SVH
`define MEMORY_CONTROLLER_REGISTER_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS
`define MCRW_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("mcrw assertion failed");
`define MCRW_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("mcrw assertion failed");
`else
`define MCRW_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define MCRW_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

@@ design/mcrw_pkg.sv @@
`default_nettype none
package mcrw_pkg;

  localparam int unsigned WINDOW_WORDS_DEF = 16384;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd16;

  localparam logic [19:0] CACHE_OP_BYTE     = 20'h0f044;
  localparam logic [19:0] MAP_FIRST_BYTE    = 20'h0f000;
  localparam logic [19:0] MAP_LAST_BYTE     = 20'h0f03c;
  localparam logic [19:0] STATUS_FIRST_BYTE = 20'h04000;
  localparam logic [19:0] STATUS_END_BYTE   = 20'h08000;

  localparam logic [31:0] CACHE_OP_SELF_CLEAR = 32'h0000_0006;
  localparam logic [31:0] CACHE_OP_INVALIDATE = 32'h0000_0004;

  localparam logic CFG_REG_DEBOUNCE = 1'b0;

  typedef enum logic [1:0] {
    ACT_READ       = 2'd0,
    ACT_WRITE      = 2'd1,
    ACT_FLUSH_DONE = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] m;
    unique case (size)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

@@ design/memory_controller_register_window.sv @@
// Register window of WINDOW_WORDS 32-bit words behind a valid/stall request channel.
// When a request is accepted its word is read from the synchronous memory; the word is
// merged and written back when the request leaves the s1 register, and the result is
// loaded into the output register at that moment; back-to-back requests to the same word are
// forwarded, so one request per cycle is sustained while out_stall is low. After
// reset the memory is cleared one word per cycle, all WINDOW_WORDS (16384 by default),
// and in_stall stays high until the clear is done; APB writes are taken throughout.
// debounce_ticks sits at APB byte address 0.
`default_nettype none
`include "memory_controller_register_window_assert.svh"
module memory_controller_register_window
  import mcrw_pkg::*;
#(
  parameter int unsigned WINDOW_WORDS = WINDOW_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [19:0] in_byte_offset,
  input  wire logic [2:0]  in_access_size,
  input  wire logic [31:0] in_write_data,
  input  wire logic [63:0] in_now_tick,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_remap_request,
  output logic             out_flush_pending,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(WINDOW_WORDS);

  logic          in_accept;
  logic          ram_busy;
  logic [31:0]   ram_rdata;
  logic          ram_we;
  logic [15:0]   debounce_ticks;

  logic          s1_valid_r;
  action_t       s1_action_r;
  logic [19:0]   s1_offset_r;
  logic [2:0]    s1_size_r;
  logic [31:0]   s1_data_r;
  logic [63:0]   s1_tick_r;
  logic          s1_fire;

  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  logic [31:0]   fwd_data_r;

  logic          pending_r;
  logic          pending_nxt;
  logic [63:0]   last_tick_r;
  logic          seen_r;

  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [31:0]   out_rdata_r;
  logic          out_remap_r;
  logic          out_pending_r;

  logic [17:0]   s1_widx;
  logic [AW-1:0] s1_addr;
  logic          s1_inwin;
  logic [19:0]   s1_aligned;
  logic [4:0]    s1_shift;
  logic [31:0]   s1_mask;
  logic [31:0]   s1_lane;
  logic [31:0]   s1_cur;
  logic [31:0]   s1_merged;
  logic [31:0]   s1_rd;
  logic          s1_is_write;
  logic          s1_remap;
  logic          s1_discard;
  logic [63:0]   s1_elapsed;
  logic          s1_debounce_ok;

  mcrw_apb u_apb (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .debounce_ticks (debounce_ticks)
  );

  mcrw_ram #(
    .WINDOW_WORDS (WINDOW_WORDS)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_byte_offset[AW+1:2]),
    .rd_data (ram_rdata),
    .wr_en   (ram_we),
    .wr_addr (s1_addr),
    .wr_data (s1_merged),
    .busy    (ram_busy)
  );

  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = ram_busy || (s1_valid_r && !s1_fire);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_widx        = s1_offset_r[19:2];
    s1_addr        = s1_widx[AW-1:0];
    s1_inwin       = {1'b0, s1_widx} < 19'(WINDOW_WORDS);
    s1_aligned     = {s1_offset_r[19:2], 2'b00};
    s1_shift       = {s1_offset_r[1:0], 3'b000};
    s1_mask        = size_mask(s1_size_r);
    s1_lane        = s1_mask << s1_shift;
    s1_cur         = (fwd_valid_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : ram_rdata;
    s1_merged      = (s1_cur & ~s1_lane) | ((s1_data_r << s1_shift) & s1_lane);
    if (s1_aligned == CACHE_OP_BYTE) begin
      s1_merged = s1_merged & ~CACHE_OP_SELF_CLEAR;
    end
    s1_rd          = (s1_cur >> s1_shift) & s1_mask;
    s1_is_write    = (s1_action_r == ACT_WRITE) && s1_inwin;
    s1_remap       = s1_is_write && (s1_aligned >= MAP_FIRST_BYTE)
                     && (s1_aligned <= MAP_LAST_BYTE);
    s1_discard     = s1_is_write
                     && (((s1_aligned >= STATUS_FIRST_BYTE) && (s1_aligned < STATUS_END_BYTE))
                     || ((s1_aligned == CACHE_OP_BYTE)
                     && ((s1_data_r & CACHE_OP_INVALIDATE) != 32'd0)));
    s1_elapsed     = s1_tick_r - last_tick_r;
    s1_debounce_ok = !seen_r || (s1_elapsed >= {48'd0, debounce_ticks});
  end

  assign ram_we = s1_fire && s1_is_write;

  always_comb begin
    pending_nxt = pending_r;
    if (s1_fire) begin
      if (s1_action_r == ACT_FLUSH_DONE) begin
        pending_nxt = 1'b0;
      end else if (s1_discard && !pending_r && s1_debounce_ok) begin
        pending_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      pending_r   <= 1'b0;
      last_tick_r <= '1;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (ram_we) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_fire && s1_discard) begin
        last_tick_r <= s1_tick_r;
        seen_r      <= 1'b1;
      end
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= action_t'(in_action);
      s1_offset_r <= in_byte_offset;
      s1_size_r   <= in_access_size;
      s1_data_r   <= in_write_data;
      s1_tick_r   <= in_now_tick;
    end
    if (ram_we) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= s1_merged;
    end
    if (s1_fire) begin
      out_rdata_r   <= ((s1_action_r == ACT_READ) && s1_inwin) ? s1_rd : 32'd0;
      out_remap_r   <= s1_remap;
      out_pending_r <= pending_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rdata_r;
  assign out_remap_request = out_remap_r;
  assign out_flush_pending = out_pending_r;

  `MCRW_ASSERT_NXT(a_flush_done_clears, clk, rst_n,
    s1_fire && (s1_action_r == ACT_FLUSH_DONE), !out_flush_pending && !pending_r)
  `MCRW_ASSERT_NXT(a_pending_needs_request, clk, rst_n,
    !s1_fire && !pending_r, !pending_r)
  `MCRW_ASSERT_IMP(a_remap_no_data, clk, rst_n,
    out_valid_r && out_remap_r, out_rdata_r == 32'd0)
  `MCRW_ASSERT_IMP(a_idle_while_clear, clk, rst_n,
    ram_busy, !s1_valid_r && !out_valid_r)

endmodule
`default_nettype wire

@@ design/mcrw_apb.sv @@
`default_nettype none
module mcrw_apb
  import mcrw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      debounce_ticks
);

  logic [15:0] deb_r;
  logic [15:0] deb_nxt;
  logic        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == CFG_REG_DEBOUNCE);

  always_comb begin
    deb_nxt = deb_r;
    if (wr_hit) begin
      deb_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= DEBOUNCE_RESET;
    end else begin
      deb_r <= deb_nxt;
    end
  end

  assign prdata = (paddr[2] == CFG_REG_DEBOUNCE) ? {16'd0, deb_r} : 32'd0;
  assign debounce_ticks = deb_r;

endmodule
`default_nettype wire

@@ design/mcrw_ram.sv @@
`default_nettype none
module mcrw_ram
  import mcrw_pkg::*;
#(
  parameter int unsigned WINDOW_WORDS = WINDOW_WORDS_DEF,
  localparam int unsigned AW = $clog2(WINDOW_WORDS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  output logic               busy
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } ram_state_t;

  ram_state_t    state_r;
  ram_state_t    state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;
  logic [31:0]   mem [WINDOW_WORDS];
  logic [31:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    mem_we      = wr_en;
    mem_waddr   = wr_addr;
    mem_wdata   = wr_data;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = 32'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(WINDOW_WORDS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = (state_r == ST_CLEAR);

endmodule
`default_nettype wire

@@ sim/tb_memory_controller_register_window.sv @@
`timescale 1ns / 100ps

module tb_memory_controller_register_window;
  import mcrw_pkg::*;

  localparam int WORDS = WINDOW_WORDS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_REQUESTS = 280;
  localparam logic [2:0] DEBOUNCE_ADDR = 3'(4 * CFG_REG_DEBOUNCE);

  typedef struct packed {
    action_t     act;
    logic [19:0] offset;
    logic [2:0]  size;
    logic [31:0] data;
    logic [63:0] tick;
  } bus_req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        remap;
    logic        pend;
  } window_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_READ;
  logic [19:0] in_byte_offset = '0;
  logic [2:0]  in_access_size = '0;
  logic [31:0] in_write_data = '0;
  logic [63:0] in_now_tick = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_remap_request;
  logic        out_flush_pending;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block
  logic [31:0] shadow_words [WORDS];
  logic        flush_model;
  logic [63:0] last_discard;
  logic        discard_seen;
  logic [15:0] debounce_model;

  window_result_t pending_results[$];

  int errors = 0;
  int cycles = 0;
  int sent_count = 0;
  int checked_count = 0;
  int n_discard = 0;
  int n_flush_set = 0;
  int n_remap = 0;
  int n_outside = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_cycles = 0;
  int rx_wait = 0;
  logic [63:0] tick_now = '0;

  memory_controller_register_window DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_byte_offset    (in_byte_offset),
    .in_access_size    (in_access_size),
    .in_write_data     (in_write_data),
    .in_now_tick       (in_now_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_remap_request (out_remap_request),
    .out_flush_pending (out_flush_pending),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic window_result_t predict_window(input bus_req_t rq);
    window_result_t r;
    logic [31:0] lane_mask;
    logic [31:0] lane;
    logic [31:0] word;
    logic [19:0] base;
    logic [4:0]  shamt;
    int          idx;
    logic        in_win;
    logic        discard;
    r = '0;
    base = {rq.offset[19:2], 2'b00};
    shamt = {rq.offset[1:0], 3'b000};
    idx = int'(rq.offset >> 2);
    in_win = idx < WORDS;
    case (rq.size)
      3'd1:    lane_mask = 32'h0000_00ff;
      3'd2:    lane_mask = 32'h0000_ffff;
      default: lane_mask = 32'hffff_ffff;
    endcase
    if (!in_win && (rq.act == ACT_READ || rq.act == ACT_WRITE))
      n_outside++;
    case (rq.act)
      ACT_READ: begin
        if (in_win)
          r.rdata = (shadow_words[idx] >> shamt) & lane_mask;
      end
      ACT_WRITE: begin
        if (in_win) begin
          lane = lane_mask << shamt;
          word = shadow_words[idx];
          word = (word & ~lane) | ((rq.data << shamt) & lane);
          if (base == CACHE_OP_BYTE)
            word = word & ~CACHE_OP_SELF_CLEAR;
          shadow_words[idx] = word;
          if (base >= MAP_FIRST_BYTE && base <= MAP_LAST_BYTE) begin
            r.remap = 1'b1;
            n_remap++;
          end
          discard = (base >= STATUS_FIRST_BYTE && base < STATUS_END_BYTE) ||
                    (base == CACHE_OP_BYTE && (rq.data & CACHE_OP_INVALIDATE) != '0);
          if (discard) begin
            n_discard++;
            if (!flush_model &&
                (!discard_seen || rq.tick - last_discard >= 64'(debounce_model))) begin
              flush_model = 1'b1;
              n_flush_set++;
            end
            last_discard = rq.tick;
            discard_seen = 1'b1;
          end
        end
      end
      ACT_FLUSH_DONE: flush_model = 1'b0;
      default: ;
    endcase
    r.pend = flush_model;
    return r;
  endfunction

  // valid is held across back-to-back requests, lowered only for a gap
  task automatic send_request(input action_t act, input logic [19:0] offset,
                              input logic [2:0] size, input logic [31:0] data,
                              input logic [63:0] tick);
    int gap;
    bus_req_t rq;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    rq = '{act, offset, size, data, tick};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_byte_offset <= offset;
    in_access_size <= size;
    in_write_data <= data;
    in_now_tick <= tick;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_window(rq));
    sent_count++;
  endtask

  function automatic logic [19:0] pick_offset();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 20'($urandom_range(0, 63));
    if (sel < 50) return 20'($urandom_range(STATUS_FIRST_BYTE, STATUS_END_BYTE - 1));
    if (sel < 60) return 20'($urandom_range(MAP_FIRST_BYTE, MAP_LAST_BYTE + 3));
    if (sel < 70) return 20'($urandom_range(CACHE_OP_BYTE, CACHE_OP_BYTE + 3));
    if (sel < 80) return 20'($urandom);
    if (sel < 90) return 20'($urandom_range(0, WORDS * 4 - 1));
    return 20'($urandom_range(WORDS * 4 - 16, WORDS * 4 + 15));
  endfunction

  task automatic send_random_request();
    int pick;
    action_t act;
    logic [2:0] size;
    pick = $urandom_range(0, 99);
    act = pick < 40 ? ACT_READ : pick < 85 ? ACT_WRITE : pick < 95 ? ACT_FLUSH_DONE : ACT_NONE;
    pick = $urandom_range(0, 99);
    if (pick < 30) size = 3'd1;
    else if (pick < 55) size = 3'd2;
    else if (pick < 85) size = 3'd4;
    else size = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 19) == 0)
      tick_now = {$urandom, $urandom};
    else
      tick_now = tick_now + 64'($urandom_range(0, 2 * int'(debounce_model) + 4));
    send_request(act, pick_offset(), size, $urandom, tick_now);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write then read back; only the low 16 bits are held
  task automatic write_debounce(input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DEBOUNCE_ADDR;
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    debounce_model = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata[15:0] !== val)
      report_mismatch("debounce readback", 64'(prdata), 64'(val));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: per-result random wait while rx_idle is set, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
      out_stall <= (rx_wait != 0);
      if (rx_wait != 0)
        rx_wait = rx_wait - 1;
    end
  end

  always @(posedge clk) begin : check_results
    window_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request", 64'(out_read_data), 64'(0));
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_read_data !== want.rdata)
          report_mismatch("read_data", 64'(out_read_data), 64'(want.rdata));
        if (out_remap_request !== want.remap)
          report_mismatch("remap_request", 64'(out_remap_request), 64'(want.remap));
        if (out_flush_pending !== want.pend)
          report_mismatch("flush_pending", 64'(out_flush_pending), 64'(want.pend));
      end
    end
  end

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_request(ACT_READ, 20'h00000, 3'd4, 32'h0, 64'd100);
    send_request(ACT_WRITE, 20'h00000, 3'd4, 32'hffff_ffff, 64'd100);
    send_request(ACT_WRITE, 20'h00001, 3'd1, 32'hffff_ff5a, 64'd100);
    send_request(ACT_READ, 20'h00002, 3'd2, 32'h0, 64'd100);
    // halfword at the top lane: upper byte falls off the word
    send_request(ACT_READ, 20'h00003, 3'd2, 32'h0, 64'd100);
    send_request(ACT_WRITE, 20'h00003, 3'd2, 32'h0000_1234, 64'd100);
    send_request(ACT_READ, 20'h00000, 3'd0, 32'h0, 64'd100);
    send_request(ACT_WRITE, 20'h00004, 3'd7, 32'h89ab_cdef, 64'd100);
    send_request(ACT_READ, 20'h00006, 3'd5, 32'h0, 64'd100);
    send_request(ACT_WRITE, MAP_FIRST_BYTE, 3'd4, 32'h1234_5678, 64'd100);
    send_request(ACT_WRITE, MAP_LAST_BYTE + 20'd3, 3'd1, 32'h0000_00a5, 64'd100);
    send_request(ACT_WRITE, MAP_LAST_BYTE + 20'd4, 3'd4, 32'h0000_0001, 64'd100);
    // invalidate on the cache-op word: first discard sets the flag
    send_request(ACT_WRITE, CACHE_OP_BYTE, 3'd4, 32'hffff_ffff, 64'd100);
    send_request(ACT_READ, CACHE_OP_BYTE, 3'd4, 32'h0, 64'd100);
    send_request(ACT_FLUSH_DONE, 20'h00000, 3'd4, 32'h0, 64'd100);
    send_request(ACT_WRITE, STATUS_FIRST_BYTE, 3'd2, 32'h0000_beef, 64'd110);
    send_request(ACT_WRITE, STATUS_END_BYTE - 20'd1, 3'd1, 32'h0000_0011, 64'd126);
    send_request(ACT_WRITE, STATUS_END_BYTE, 3'd4, 32'hdead_beef, 64'd200);
    send_request(ACT_FLUSH_DONE, 20'hfffff, 3'd7, 32'hffff_ffff, 64'd200);
    // lane write with invalidate bit in the unshifted data
    send_request(ACT_WRITE, CACHE_OP_BYTE + 20'd1, 3'd1, 32'h0000_0004,
                 64'hffff_ffff_ffff_fff8);
    send_request(ACT_FLUSH_DONE, 20'h00000, 3'd4, 32'h0, 64'hffff_ffff_ffff_fff8);
    // tick wrap across zero
    send_request(ACT_WRITE, 20'h05000, 3'd4, 32'h5555_aaaa, 64'd8);
    send_request(ACT_WRITE, 20'(WORDS * 4), 3'd4, 32'hffff_ffff, 64'd8);
    send_request(ACT_READ, 20'hfffff, 3'd1, 32'h0, 64'd8);
    send_request(ACT_NONE, 20'h00000, 3'd4, 32'hffff_ffff, 64'd8);
    send_request(ACT_READ, 20'(WORDS * 4 - 4), 3'd4, 32'h0, 64'd8);
    tick_now = 64'd8;
    wait_for_results();
  endtask

  task automatic test_random_phase(input logic [15:0] deb, input int count,
                                   input bit idle_on);
    write_debounce(deb);
    tx_idle = idle_on;
    rx_idle = idle_on;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        wait_for_results();
      send_random_request();
    end
    wait_for_results();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_cycles = 200;
    repeat (60) send_random_request();
    wait_for_results();
  endtask

  initial begin
    foreach (shadow_words[i]) shadow_words[i] = '0;
    flush_model = 1'b0;
    last_discard = '1;
    discard_seen = 1'b0;
    debounce_model = DEBOUNCE_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phase(16'd0, PHASE_REQUESTS, 1'b1);
    test_random_phase(16'hffff, PHASE_REQUESTS, 1'b1);
    test_random_phase(16'($urandom_range(1, 65534)), PHASE_REQUESTS, 1'b0);
    test_backpressure();
    test_random_phase(16'($urandom_range(1, 64)), PHASE_REQUESTS, 1'b1);
    $display("covered %0d requests, %0d results checked, debounce 0, 65535 and random",
             sent_count, checked_count);
    $display("discards %0d, flush sets %0d, remaps %0d, out-of-window accesses %0d",
             n_discard, n_flush_set, n_remap, n_outside);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/mcrw_pkg.sv
design/mcrw_apb.sv
design/mcrw_ram.sv
design/memory_controller_register_window.sv
sim/tb_memory_controller_register_window.sv
